// ----- rtl/tftpc_pkg.sv -----
// Shared types and constants for the TFTP client transfer controller.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tftpc_pkg;

    // Field widths fixed by the packet and file formats.
    localparam int KIND_W   = 3;
    localparam int BLOCK_W  = 16;
    localparam int DLEN_W   = 10;
    localparam int ACT_W    = 4;
    localparam int LEN_W    = 10;
    localparam int POS_W    = 25;
    localparam int CFG_IDX_W = 1;

    // Event kinds as they arrive on the input.
    localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DATA    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACK     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd5;

    // Actions reported with each result.
    localparam logic [ACT_W-1:0] ACT_NONE   = 4'd0;
    localparam logic [ACT_W-1:0] ACT_RRQ    = 4'd1;
    localparam logic [ACT_W-1:0] ACT_WRQ    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_ACK    = 4'd3;
    localparam logic [ACT_W-1:0] ACT_NEW    = 4'd4;
    localparam logic [ACT_W-1:0] ACT_RESEND = 4'd5;
    localparam logic [ACT_W-1:0] ACT_DONE   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_ERR    = 4'd7;
    localparam logic [ACT_W-1:0] ACT_UNK    = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'd1;

    // Header bytes in a data datagram.
    localparam logic [DLEN_W-1:0] HDR_BYTES = 10'd4;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Classified event as it travels from front to back.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;      // one of KIND_START .. KIND_UNKNOWN
        logic [BLOCK_W-1:0] block;     // received block number
        logic [LEN_W-1:0]   plen;      // payload bytes, saturated
        logic               short_blk; // payload shorter than a full block
    } t_evt;

endpackage

// ----- rtl/tftpc_front.sv -----
// Front end: accepts input items, folds the event kind into a known class
// and derives the saturated payload length. Depends on tftpc_pkg.
module tftpc_front
    import tftpc_pkg::*;
#(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [KIND_W-1:0]   i_event_kind,
    input  logic [BLOCK_W-1:0]  i_packet_block,
    input  logic [DLEN_W-1:0]   i_datagram_length,
    input  logic                i_q_full,
    output logic                o_push,
    output t_evt                o_evt
);

    localparam logic [POS_W-1:0] BLK = POS_W'(BLOCK_BYTES);

    logic [LEN_W-1:0] w_raw_len;

    // The item is taken whenever the queue has room.
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Unused kind codes collapse into the unknown class. The payload length
    // has its header removed, is floored at zero and is capped at one block.
    always_comb begin
        unique case (i_event_kind)
            KIND_START, KIND_TIMEOUT, KIND_DATA, KIND_ACK, KIND_ERROR: begin
                o_evt.kind = i_event_kind;
            end
            default: begin
                o_evt.kind = KIND_UNKNOWN;
            end
        endcase
        w_raw_len = (i_datagram_length >= HDR_BYTES) ? (i_datagram_length - HDR_BYTES)
                                                     : '0;
        if (POS_W'(w_raw_len) > BLK) begin
            o_evt.plen = BLK[LEN_W-1:0];
        end else begin
            o_evt.plen = w_raw_len;
        end
        o_evt.short_blk = (POS_W'(w_raw_len) < BLK);
        o_evt.block     = i_packet_block;
    end

endmodule

// ----- rtl/tftpc_queue.sv -----
// Short first-in first-out queue of classified events between front and back.
// Depends on tftpc_pkg for the item type and depth.
module tftpc_queue
    import tftpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_evt i_push_data,
    output logic o_full,
    output logic o_valid,
    output t_evt o_data,
    input  logic i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_evt             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == DEPTH_C);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- rtl/tftpc_back.sv -----
// Back end: holds the configuration and transfer state; depends on tftpc_pkg.
// Runs one classified event per cycle unless stalled; registers the result.
module tftpc_back
    import tftpc_pkg::*;
#(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data,
    input  logic                 i_q_valid,
    input  t_evt                 i_q_data,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ACT_W-1:0]     o_action,
    output logic [BLOCK_W-1:0]   o_out_block,
    output logic [LEN_W-1:0]     o_send_length,
    output logic [POS_W-1:0]     o_file_offset,
    output logic                 o_payload_accepted,
    output logic [LEN_W-1:0]     o_payload_length
);

    localparam logic [POS_W-1:0] BLK = POS_W'(BLOCK_BYTES);

    // Configuration.
    logic               r_mode;
    logic [POS_W-1:0]   r_size;

    // Transfer state.
    logic [BLOCK_W-1:0] r_bc, n_bc;
    logic               r_ru, n_ru;
    logic               r_final, n_final;
    logic               r_lbs, n_lbs;
    logic [POS_W-1:0]   r_rp, n_rp;
    logic [LEN_W-1:0]   r_lsl, n_lsl;

    // Result register.
    logic               r_out_valid;
    logic [ACT_W-1:0]   r_act, n_act;
    logic [BLOCK_W-1:0] r_oblk, n_oblk;
    logic [LEN_W-1:0]   r_slen, n_slen;
    logic [POS_W-1:0]   r_offs, n_offs;
    logic               r_acc, n_acc;
    logic [LEN_W-1:0]   r_plen, n_plen;

    logic [BLOCK_W-1:0] w_bc_inc;
    logic [POS_W-1:0]   w_remain;
    logic [POS_W-1:0]   w_len;

    assign o_cfg_ready = 1'b1;

    // An event leaves the queue when the result register is free or drains.
    assign o_pop = i_q_valid && (!r_out_valid || i_out_ready);

    assign w_bc_inc = r_bc + BLOCK_W'(1);
    assign w_remain = (r_size > r_rp) ? (r_size - r_rp) : '0;
    assign w_len    = (w_remain < BLK) ? w_remain : BLK;

    // Event execution against the transfer state.
    always_comb begin
        n_bc    = r_bc;
        n_ru    = r_ru;
        n_final = r_final;
        n_lbs   = r_lbs;
        n_rp    = r_rp;
        n_lsl   = r_lsl;
        n_act   = ACT_NONE;
        n_oblk  = '0;
        n_slen  = '0;
        n_offs  = '0;
        n_acc   = 1'b0;
        n_plen  = '0;
        unique case (i_q_data.kind)
            KIND_START: begin
                n_bc    = '0;
                n_ru    = 1'b1;
                n_final = 1'b0;
                n_lbs   = 1'b0;
                n_rp    = '0;
                n_lsl   = '0;
                n_act   = r_mode ? ACT_WRQ : ACT_RRQ;
            end
            KIND_TIMEOUT: begin
                if (r_ru) begin
                    n_act = r_mode ? ACT_WRQ : ACT_RRQ;
                end else if (r_mode) begin
                    n_act  = ACT_RESEND;
                    n_oblk = r_bc;
                    n_slen = r_lsl;
                end else if (r_final) begin
                    n_act = ACT_DONE;
                end else begin
                    n_act  = ACT_ACK;
                    n_oblk = r_bc;
                end
            end
            KIND_DATA: begin
                // Download: only the next block in sequence is stored.
                if (!r_mode) begin
                    n_ru   = 1'b0;
                    n_act  = ACT_ACK;
                    n_oblk = r_bc;
                    if (i_q_data.block == w_bc_inc) begin
                        n_acc  = 1'b1;
                        n_plen = i_q_data.plen;
                        n_bc   = w_bc_inc;
                        n_oblk = w_bc_inc;
                        if (i_q_data.short_blk) begin
                            n_final = 1'b1;
                        end
                    end
                end
            end
            KIND_ACK: begin
                // Upload: a matching ack frees the next block or finishes.
                if (r_mode) begin
                    n_ru = 1'b0;
                    if (i_q_data.block == r_bc) begin
                        if (r_lbs) begin
                            n_act = ACT_DONE;
                        end else begin
                            if (w_remain < BLK) begin
                                n_lbs = 1'b1;
                            end
                            n_bc   = w_bc_inc;
                            n_act  = ACT_NEW;
                            n_oblk = w_bc_inc;
                            n_offs = r_rp;
                            n_slen = w_len[LEN_W-1:0];
                            n_lsl  = w_len[LEN_W-1:0];
                            n_rp   = r_rp + w_len;
                        end
                    end else begin
                        n_act  = ACT_RESEND;
                        n_oblk = r_bc;
                        n_slen = r_lsl;
                    end
                end
            end
            KIND_ERROR: begin
                n_act = ACT_ERR;
            end
            default: begin
                n_act = ACT_UNK;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_size <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE: r_mode <= i_cfg_data[0];
                CFG_SIZE: r_size <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Transfer state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc        <= '0;
            r_ru        <= 1'b1;
            r_final     <= 1'b0;
            r_lbs       <= 1'b0;
            r_rp        <= '0;
            r_lsl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_bc    <= n_bc;
                r_ru    <= n_ru;
                r_final <= n_final;
                r_lbs   <= n_lbs;
                r_rp    <= n_rp;
                r_lsl   <= n_lsl;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_act  <= n_act;
            r_oblk <= n_oblk;
            r_slen <= n_slen;
            r_offs <= n_offs;
            r_acc  <= n_acc;
            r_plen <= n_plen;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_action           = r_act;
    assign o_out_block        = r_oblk;
    assign o_send_length      = r_slen;
    assign o_file_offset      = r_offs;
    assign o_payload_accepted = r_acc;
    assign o_payload_length   = r_plen;

endmodule

// ----- rtl/tftp_client_transfer_controller.sv -----
// Stop-and-wait TFTP client controller: one event in, one action out.
// An accepted event passes through the queue, then the result register, before its result is valid.
// Throughput: one event per cycle while results are drained, set by the state update in the back end.
// A two-entry queue between front and back lets either side stall on its own.
// Reset (synchronous, active low) empties the queue and result register and
// returns configuration and transfer state to their initial values.
module tftp_client_transfer_controller
    import tftpc_pkg::*;
#(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [KIND_W-1:0]    i_event_kind,
    input  logic [BLOCK_W-1:0]   i_packet_block,
    input  logic [DLEN_W-1:0]    i_datagram_length,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ACT_W-1:0]     o_action,
    output logic [BLOCK_W-1:0]   o_out_block,
    output logic [LEN_W-1:0]     o_send_length,
    output logic [POS_W-1:0]     o_file_offset,
    output logic                 o_payload_accepted,
    output logic [LEN_W-1:0]     o_payload_length
);

    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;
    t_evt w_push_evt;
    t_evt w_q_evt;

    // Accept and classify.
    tftpc_front #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_front (
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_event_kind     (i_event_kind),
        .i_packet_block   (i_packet_block),
        .i_datagram_length(i_datagram_length),
        .i_q_full         (w_full),
        .o_push           (w_push),
        .o_evt            (w_push_evt)
    );

    // Decoupling queue.
    tftpc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_data(w_push_evt),
        .o_full     (w_full),
        .o_valid    (w_q_valid),
        .o_data     (w_q_evt),
        .i_pop      (w_pop)
    );

    // Execute and deliver.
    tftpc_back #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_q_valid         (w_q_valid),
        .i_q_data          (w_q_evt),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_action          (o_action),
        .o_out_block       (o_out_block),
        .o_send_length     (o_send_length),
        .o_file_offset     (o_file_offset),
        .o_payload_accepted(o_payload_accepted),
        .o_payload_length  (o_payload_length)
    );

endmodule

// ----- rtl/tftpc_checker.sv -----
// Port-level checks for the TFTP client controller, bound to the top level.
// Depends on tftpc_pkg and tftp_client_transfer_controller.
module tftpc_checker
    import tftpc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [ACT_W-1:0]     o_action,
    input logic [POS_W-1:0]     o_file_offset,
    input logic                 o_payload_accepted,
    input logic [LEN_W-1:0]     o_payload_length
);

    // A stalled result holds its action.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_action))
        else $error("result changed while stalled");

    // An item accepted while no result waits shows a result once it has passed the queue and the result register.
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |-> ##2 o_out_valid)
        else $error("accepted item produced no result");

    // An accepted payload is always answered with an ack.
    a_acc_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_accepted |-> o_action == ACT_ACK)
        else $error("accepted payload without ack");

    // Offset and payload length appear only with their own actions.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_action == ACT_NEW || o_file_offset == '0) &&
                        (o_payload_accepted || o_payload_length == '0))
        else $error("stray offset or payload length");

endmodule

bind tftp_client_transfer_controller tftpc_checker u_tftpc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_action          (o_action),
    .o_file_offset     (o_file_offset),
    .o_payload_accepted(o_payload_accepted),
    .o_payload_length  (o_payload_length)
);
